// ===== sv/sfe_pkg.sv =====
// ----------------------------------------------------------------------------
// sfe_pkg: shared types and constants of the stack frame engine
// Word stack geometry, operation codes, sequencer states and the structs
// that connect the sequencer, the stack RAM and the top level.
// ----------------------------------------------------------------------------
package sfe_pkg;

   // Depth of the word stack. It must be a power of two, so that the word
   // index is a plain bit field of the byte offset.
   localparam int STACK_WORDS = 1024;
   localparam int IDX_W       = $clog2(STACK_WORDS);
   localparam int WORD_W      = 16;
   localparam int NEST_W      = 8;
   localparam int KIND_W      = 3;
   // Enter uses the nesting byte modulo 32, so a five-bit counter covers it.
   localparam int CNT_W       = 5;
   localparam int SEL_W       = 3;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [WORD_W-1:0] word_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [SEL_W-1:0]  sel_type;

   localparam word_type WORD_STEP = word_type'(2);
   localparam sel_type  SEL_LAST  = sel_type'(7);
   localparam cnt_type  CNT_ONE   = cnt_type'(1);
   localparam cnt_type  CNT_ZERO  = cnt_type'(0);
   localparam idx_type  IDX_LAST  = idx_type'(STACK_WORDS - 1);

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH_WORD = 3'd0,
      KIND_PUSH_BYTE = 3'd1,
      KIND_PUSH_ALL  = 3'd2,
      KIND_POP_ALL   = 3'd3,
      KIND_ENTER     = 3'd4,
      KIND_LEAVE     = 3'd5
   } kind_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PUSH,
      ST_POP,
      ST_POP_LAST,
      ST_ENT_BP,
      ST_ENT_RD,
      ST_ENT_WR,
      ST_ENT_TEMP,
      ST_ENT_SIZE,
      ST_LEAVE_RD,
      ST_LEAVE_WB,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic     we;
      idx_type  addr;
      word_type wdata;
   } mem_req_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      word_type          sp;
      word_type          bp;
      word_type          ax;
      word_type          bx;
      word_type          cx;
      word_type          dx;
      word_type          si;
      word_type          di;
      word_type          frame_size;
      logic [NEST_W-1:0] nesting;
      word_type          push_value;
   } req_type;

   typedef struct packed {
      word_type sp;
      word_type bp;
      word_type ax;
      word_type bx;
      word_type cx;
      word_type dx;
      word_type si;
      word_type di;
   } result_type;

   // Word index of a byte offset, modulo the stack depth.
   function automatic idx_type word_idx(input word_type off);
      return off[IDX_W:1];
   endfunction

endpackage

// ===== sv/stack_frame_engine.sv =====
// ----------------------------------------------------------------------------
// stack_frame_engine: stack unit with push, push/pop-all, enter and leave
// Top level: request capture, result register, sequencer and stack RAM.
// ----------------------------------------------------------------------------
// Usage:
// Each request transfer carries one stack operation with the current SP,
// BP and general registers; each response transfer returns SP, BP and the
// registers after it. The unit owns a word stack memory addressed by
// offset/2 modulo its depth, with one access per cycle through a single
// port. Each step of an operation makes at most one memory access, and
// one 16-bit adder serves all pointer arithmetic. One operation is in
// flight at a time; req_ready is high only while the sequencer is idle,
// so no new request is taken until the sequencer has handed on its
// result. A finished response waits in an output register; the next
// request is taken while it waits, and a second result stalls until it
// is taken. After reset a clearing pass writes zero to all 1024 stack
// words, one per cycle, and req_ready stays low until the pass ends.
// ----------------------------------------------------------------------------
module stack_frame_engine
   import sfe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [15:0] req_stack_ptr,
   input  logic [15:0] req_base_ptr,
   input  logic [15:0] req_reg_ax,
   input  logic [15:0] req_reg_bx,
   input  logic [15:0] req_reg_cx,
   input  logic [15:0] req_reg_dx,
   input  logic [15:0] req_reg_si,
   input  logic [15:0] req_reg_di,
   input  logic [15:0] req_frame_size,
   input  logic [7:0]  req_nesting_level,
   input  logic [15:0] req_push_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_new_stack_ptr,
   output logic [15:0] rsp_new_base_ptr,
   output logic [15:0] rsp_out_ax,
   output logic [15:0] rsp_out_bx,
   output logic [15:0] rsp_out_cx,
   output logic [15:0] rsp_out_dx,
   output logic [15:0] rsp_out_si,
   output logic [15:0] rsp_out_di
);

   req_type     req;
   result_type  done_data;
   logic        done_valid;
   logic        done_ready;
   mem_req_type mem_req;
   word_type    mem_rdata;

   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff, rsp_in;

   assign req.kind       = req_kind;
   assign req.sp         = req_stack_ptr;
   assign req.bp         = req_base_ptr;
   assign req.ax         = req_reg_ax;
   assign req.bx         = req_reg_bx;
   assign req.cx         = req_reg_cx;
   assign req.dx         = req_reg_dx;
   assign req.si         = req_reg_si;
   assign req.di         = req_reg_di;
   assign req.frame_size = req_frame_size;
   assign req.nesting    = req_nesting_level;
   assign req.push_value = req_push_value;

   sfe_core u_core (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req        (req),
      .done_valid (done_valid),
      .done_ready (done_ready),
      .done_data  (done_data),
      .mem_req    (mem_req),
      .mem_rdata  (mem_rdata)
   );

   sfe_stack_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (mem_rdata)
   );

   // The result register takes a new result when it is empty or is being
   // emptied by a transfer in the same cycle.
   assign done_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (done_valid && done_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = done_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_new_stack_ptr = rsp_ff.sp;
   assign rsp_new_base_ptr  = rsp_ff.bp;
   assign rsp_out_ax        = rsp_ff.ax;
   assign rsp_out_bx        = rsp_ff.bx;
   assign rsp_out_cx        = rsp_ff.cx;
   assign rsp_out_dx        = rsp_ff.dx;
   assign rsp_out_si        = rsp_ff.si;
   assign rsp_out_di        = rsp_ff.di;

`ifndef NO_ASSERTIONS
   // The clearing pass follows reset, so no request is taken right after it.
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request accepted during the clearing pass");

   // Every operation takes the sequencer out of idle, so req_ready drops after a request transfer.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sequencer ready right after a request transfer");

   // A result is loaded only from the done state, never while idle.
   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared while the sequencer was idle");

   // The sequencer holds its result until the output register takes it.
   a_done_held: assert property (@(posedge clock) disable iff (reset)
      done_valid && !done_ready |=> done_valid && $stable(done_data))
      else $error("finished result dropped before the output register took it");
`endif

endmodule

// ===== sv/sfe_stack_ram.sv =====
// ----------------------------------------------------------------------------
// sfe_stack_ram: single-port word stack memory
// One access per cycle: a write, or a read whose data is registered and
// appears in the next cycle.
// ----------------------------------------------------------------------------
module sfe_stack_ram
   import sfe_pkg::*;
(
   input  logic        clock,
   input  mem_req_type mem_req,
   output word_type    rdata
);

   word_type mem [STACK_WORDS];
   word_type rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.addr] <= mem_req.wdata;
      end
      rdata_ff <= mem[mem_req.addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/sfe_core.sv =====
// ----------------------------------------------------------------------------
// sfe_core: stack operation sequencer
// Walks each operation through steps of at most one stack access per cycle, with
// one shared 16-bit adder for all SP, BP and frame-walk arithmetic. Also
// runs the clearing pass of the stack memory after reset.
// ----------------------------------------------------------------------------
module sfe_core
   import sfe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req,
   output logic        done_valid,
   input  logic        done_ready,
   output result_type  done_data,
   output mem_req_type mem_req,
   input  word_type    mem_rdata
);

   state_type state_ff, state_in;
   cnt_type   cnt_ff, cnt_in;
   idx_type   clr_ff, clr_in;
   kind_type  kind_ff, kind_in;
   word_type  sp_ff, sp_in;
   word_type  bp_ff, bp_in;
   word_type  ax_ff, ax_in;
   word_type  bx_ff, bx_in;
   word_type  cx_ff, cx_in;
   word_type  dx_ff, dx_in;
   word_type  si_ff, si_in;
   word_type  di_ff, di_in;
   word_type  osp_ff, osp_in;
   word_type  walk_ff, walk_in;
   word_type  temp_ff, temp_in;
   word_type  size_ff, size_in;
   word_type  imm_ff, imm_in;
   logic      pop_vld_ff, pop_vld_in;
   sel_type   pop_sel_ff, pop_sel_in;

   // Shared adder: sum = a + b + cin.
   word_type  add_a;
   word_type  add_b;
   logic      add_cin;
   word_type  add_sum;
   word_type  push_val;

   assign add_sum = add_a + add_b + {{(WORD_W-1){1'b0}}, add_cin};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         pop_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         pop_vld_ff <= pop_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      kind_ff    <= kind_in;
      sp_ff      <= sp_in;
      bp_ff      <= bp_in;
      ax_ff      <= ax_in;
      bx_ff      <= bx_in;
      cx_ff      <= cx_in;
      dx_ff      <= dx_in;
      si_ff      <= si_in;
      di_ff      <= di_in;
      osp_ff     <= osp_in;
      walk_ff    <= walk_in;
      temp_ff    <= temp_in;
      size_ff    <= size_in;
      imm_ff     <= imm_in;
      pop_sel_ff <= pop_sel_in;
   end

   // Word written by a push step.
   always_comb begin
      push_val = imm_ff;
      case (kind_ff)
         KIND_PUSH_BYTE: push_val = {{(WORD_W-8){imm_ff[7]}}, imm_ff[7:0]};
         KIND_PUSH_ALL: begin
            case (cnt_ff[SEL_W-1:0])
               3'd0:    push_val = ax_ff;
               3'd1:    push_val = cx_ff;
               3'd2:    push_val = dx_ff;
               3'd3:    push_val = bx_ff;
               3'd4:    push_val = osp_ff;
               3'd5:    push_val = bp_ff;
               3'd6:    push_val = si_ff;
               default: push_val = di_ff;
            endcase
         end
         default: push_val = imm_ff;
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      clr_in     = clr_ff;
      kind_in    = kind_ff;
      sp_in      = sp_ff;
      bp_in      = bp_ff;
      ax_in      = ax_ff;
      bx_in      = bx_ff;
      cx_in      = cx_ff;
      dx_in      = dx_ff;
      si_in      = si_ff;
      di_in      = di_ff;
      osp_in     = osp_ff;
      walk_in    = walk_ff;
      temp_in    = temp_ff;
      size_in    = size_ff;
      imm_in     = imm_ff;
      pop_vld_in = 1'b0;
      pop_sel_in = pop_sel_ff;

      // Default adder setting is SP - 2.
      add_a   = sp_ff;
      add_b   = ~WORD_STEP;
      add_cin = 1'b1;

      mem_req.we    = 1'b0;
      mem_req.addr  = word_idx(sp_ff);
      mem_req.wdata = push_val;

      req_ready  = 1'b0;
      done_valid = 1'b0;

      // A word read by a pop-all step arrives in the cycle after its address.
      if (pop_vld_ff) begin
         case (pop_sel_ff)
            3'd0:    di_in = mem_rdata;
            3'd1:    si_in = mem_rdata;
            3'd2:    ;
            3'd3:    bp_in = mem_rdata;
            3'd4:    bx_in = mem_rdata;
            3'd5:    dx_in = mem_rdata;
            3'd6:    cx_in = mem_rdata;
            default: ax_in = mem_rdata;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_req.we    = 1'b1;
            mem_req.addr  = clr_ff;
            mem_req.wdata = '0;
            clr_in        = clr_ff + idx_type'(1);
            if (clr_ff == IDX_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in = kind_type'(req.kind);
               sp_in   = req.sp;
               osp_in  = req.sp;
               bp_in   = req.bp;
               ax_in   = req.ax;
               bx_in   = req.bx;
               cx_in   = req.cx;
               dx_in   = req.dx;
               si_in   = req.si;
               di_in   = req.di;
               size_in = req.frame_size;
               imm_in  = req.push_value;
               cnt_in  = CNT_ZERO;
               case (kind_type'(req.kind))
                  KIND_PUSH_WORD: state_in = ST_PUSH;
                  KIND_PUSH_BYTE: state_in = ST_PUSH;
                  KIND_PUSH_ALL:  state_in = ST_PUSH;
                  KIND_POP_ALL:   state_in = ST_POP;
                  KIND_ENTER: begin
                     cnt_in   = req.nesting[CNT_W-1:0];
                     state_in = ST_ENT_BP;
                  end
                  KIND_LEAVE:     state_in = ST_LEAVE_RD;
                  default:        state_in = ST_DONE;
               endcase
            end
         end
         ST_PUSH: begin
            sp_in         = add_sum;
            mem_req.we    = 1'b1;
            mem_req.addr  = word_idx(add_sum);
            cnt_in        = cnt_ff + CNT_ONE;
            if (kind_ff != KIND_PUSH_ALL || cnt_ff[SEL_W-1:0] == SEL_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_POP: begin
            add_b      = WORD_STEP;
            add_cin    = 1'b0;
            sp_in      = add_sum;
            pop_vld_in = 1'b1;
            pop_sel_in = cnt_ff[SEL_W-1:0];
            cnt_in     = cnt_ff + CNT_ONE;
            if (cnt_ff[SEL_W-1:0] == SEL_LAST) begin
               state_in = ST_POP_LAST;
            end
         end
         ST_POP_LAST: begin
            state_in = ST_DONE;
         end
         ST_ENT_BP: begin
            sp_in         = add_sum;
            temp_in       = add_sum;
            walk_in       = bp_ff;
            mem_req.we    = 1'b1;
            mem_req.addr  = word_idx(add_sum);
            mem_req.wdata = bp_ff;
            cnt_in        = cnt_ff - CNT_ONE;
            if (cnt_ff == CNT_ZERO) begin
               state_in = ST_ENT_SIZE;
            end else if (cnt_ff == CNT_ONE) begin
               state_in = ST_ENT_TEMP;
            end else begin
               state_in = ST_ENT_RD;
            end
         end
         ST_ENT_RD: begin
            // Step the frame walk down and read the saved frame pointer.
            add_a        = walk_ff;
            walk_in      = add_sum;
            mem_req.addr = word_idx(add_sum);
            state_in     = ST_ENT_WR;
         end
         ST_ENT_WR: begin
            sp_in         = add_sum;
            mem_req.we    = 1'b1;
            mem_req.addr  = word_idx(add_sum);
            mem_req.wdata = mem_rdata;
            cnt_in        = cnt_ff - CNT_ONE;
            if (cnt_ff == CNT_ONE) begin
               state_in = ST_ENT_TEMP;
            end else begin
               state_in = ST_ENT_RD;
            end
         end
         ST_ENT_TEMP: begin
            sp_in         = add_sum;
            mem_req.we    = 1'b1;
            mem_req.addr  = word_idx(add_sum);
            mem_req.wdata = temp_ff;
            state_in      = ST_ENT_SIZE;
         end
         ST_ENT_SIZE: begin
            add_b    = ~size_ff;
            sp_in    = add_sum;
            bp_in    = temp_ff;
            state_in = ST_DONE;
         end
         ST_LEAVE_RD: begin
            add_a        = bp_ff;
            add_b        = WORD_STEP;
            add_cin      = 1'b0;
            sp_in        = add_sum;
            mem_req.addr = word_idx(bp_ff);
            state_in     = ST_LEAVE_WB;
         end
         ST_LEAVE_WB: begin
            bp_in    = mem_rdata;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            done_valid = 1'b1;
            if (done_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign done_data.sp = sp_ff;
   assign done_data.bp = bp_ff;
   assign done_data.ax = ax_ff;
   assign done_data.bx = bx_ff;
   assign done_data.cx = cx_ff;
   assign done_data.dx = dx_ff;
   assign done_data.si = si_ff;
   assign done_data.di = di_ff;

endmodule

// ===== test/stack_frame_engine_test.sv =====
// ----------------------------------------------------------------------------
// stack_frame_engine_test: self-checking testbench of the stack frame engine
// Sends push, push-all, pop-all, enter and leave operations through the
// request channel. It predicts every response against its own image of the
// stack memory and checks the response fields in order. Both channels idle
// and stall at random. Directed corner cases come first, then a long hold-off
// of the response side, then random procedure frames mixed with stray
// operations.
// ----------------------------------------------------------------------------
module stack_frame_engine_test
   import sfe_pkg::*;
();

   localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;
   localparam int NEST_WRAP      = 32;
   localparam int RANDOM_OPS     = 480;
   localparam int PRESSURE_ITEMS = 16;
   localparam int HOLD_CYCLES    = 400;
   localparam int MAX_GAP        = 20;
   localparam int MAX_BURST      = 12;
   localparam int DRAIN_CYCLES   = 100;
   localparam int CYCLE_LIMIT    = 400000;

   typedef enum int {SINK_STEADY, SINK_COIN, SINK_SPARSE, SINK_PERIODIC} sink_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_kind = '0;
   logic [15:0] req_stack_ptr = '0;
   logic [15:0] req_base_ptr = '0;
   logic [15:0] req_reg_ax = '0;
   logic [15:0] req_reg_bx = '0;
   logic [15:0] req_reg_cx = '0;
   logic [15:0] req_reg_dx = '0;
   logic [15:0] req_reg_si = '0;
   logic [15:0] req_reg_di = '0;
   logic [15:0] req_frame_size = '0;
   logic [7:0]  req_nesting_level = '0;
   logic [15:0] req_push_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_new_stack_ptr;
   logic [15:0] rsp_new_base_ptr;
   logic [15:0] rsp_out_ax;
   logic [15:0] rsp_out_bx;
   logic [15:0] rsp_out_cx;
   logic [15:0] rsp_out_dx;
   logic [15:0] rsp_out_si;
   logic [15:0] rsp_out_di;

   // Prediction state: an image of the stack memory and the working SP.
   word_type   stack_image [STACK_WORDS];
   word_type   model_sp;
   result_type pending_results [$];
   result_type oldest_pending;
   word_type   chain_sp;
   word_type   chain_bp;

   int         mismatches = 0;
   int         responses_checked = 0;
   int         ops_sent = 0;
   int         deep_enters = 0;
   int         kind_count [8];
   int         burst_left = 0;
   int         cycle_count = 0;
   int         hold_request = 0;
   int         hold_left = 0;
   int         longest_hold = 0;
   int         pattern_left = 0;
   sink_mode_type pattern_mode = SINK_STEADY;

   stack_frame_engine u_dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      foreach (stack_image[i]) stack_image[i] = '0;
      foreach (kind_count[i]) kind_count[i] = 0;
   end

   // ---------------------------------------------------------------- model
   function automatic int unsigned slot_of(word_type off);
      return (32'(off) >> 1) % STACK_WORDS;
   endfunction

   function automatic void push_model(word_type value);
      model_sp -= WORD_STEP;
      stack_image[slot_of(model_sp)] = value;
   endfunction

   function automatic word_type pop_model();
      word_type value;
      value = stack_image[slot_of(model_sp)];
      model_sp += WORD_STEP;
      return value;
   endfunction

   function automatic result_type compute_stack_result(req_type r);
      result_type res;
      word_type   frame_temp;
      word_type   walk;
      word_type   entry_sp;
      int         level;
      int         step;
      res = '{sp: r.sp, bp: r.bp, ax: r.ax, bx: r.bx, cx: r.cx, dx: r.dx,
              si: r.si, di: r.di};
      model_sp = r.sp;
      level = int'(r.nesting) % NEST_WRAP;
      case (r.kind)
         KIND_PUSH_WORD: push_model(r.push_value);
         KIND_PUSH_BYTE: push_model({{8{r.push_value[7]}}, r.push_value[7:0]});
         KIND_PUSH_ALL: begin
            entry_sp = model_sp;
            push_model(r.ax);
            push_model(r.cx);
            push_model(r.dx);
            push_model(r.bx);
            push_model(entry_sp);
            push_model(r.bp);
            push_model(r.si);
            push_model(r.di);
         end
         KIND_POP_ALL: begin
            res.di = pop_model();
            res.si = pop_model();
            // The saved SP slot is read and dropped.
            void'(pop_model());
            res.bp = pop_model();
            res.bx = pop_model();
            res.dx = pop_model();
            res.cx = pop_model();
            res.ax = pop_model();
         end
         KIND_ENTER: begin
            push_model(r.bp);
            frame_temp = model_sp;
            if (level != 0) begin
               walk = r.bp;
               for (step = 1; step < level; step++) begin
                  walk -= WORD_STEP;
                  push_model(stack_image[slot_of(walk)]);
               end
               push_model(frame_temp);
            end
            res.bp = frame_temp;
            model_sp -= r.frame_size;
         end
         KIND_LEAVE: begin
            model_sp = r.bp;
            res.bp = pop_model();
         end
         default: ;
      endcase
      res.sp = model_sp;
      return res;
   endfunction

   // ------------------------------------------------------------- stimulus
   function automatic word_type pick_stack_ptr();
      word_type sp;
      sp = word_type'($urandom);
      // Mostly aligned pointers, with an odd one now and then.
      if ($urandom_range(0, 9) != 0) sp[0] = 1'b0;
      return sp;
   endfunction

   function automatic logic [NEST_W-1:0] pick_nesting();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return NEST_W'($urandom_range(0, 3));
      if (roll < 92) return NEST_W'($urandom_range(4, 8));
      return NEST_W'($urandom);
   endfunction

   function automatic req_type random_request(logic [KIND_W-1:0] kind, word_type sp,
                                              word_type bp);
      req_type r;
      r.kind       = kind;
      r.sp         = sp;
      r.bp         = bp;
      r.ax         = word_type'($urandom);
      r.bx         = word_type'($urandom);
      r.cx         = word_type'($urandom);
      r.dx         = word_type'($urandom);
      r.si         = word_type'($urandom);
      r.di         = word_type'($urandom);
      r.nesting    = pick_nesting();
      r.push_value = word_type'($urandom);
      if ($urandom_range(0, 99) < 85) r.frame_size = word_type'($urandom_range(0, 32) * 2);
      else r.frame_size = word_type'($urandom);
      return r;
   endfunction

   function automatic req_type noise_request();
      req_type r;
      r = random_request(KIND_W'($urandom_range(0, 7)), word_type'($urandom),
                         word_type'($urandom));
      r.nesting    = NEST_W'($urandom);
      r.frame_size = word_type'($urandom);
      return r;
   endfunction

   // Offers one operation and returns at the edge of its transfer. The
   // source works in bursts; between bursts valid drops for a random gap.
   task automatic send_item(req_type r);
      result_type predicted;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, MAX_GAP)) @(posedge clock);
         burst_left = $urandom_range(1, MAX_BURST);
      end
      burst_left--;
      req_kind          <= r.kind;
      req_stack_ptr     <= r.sp;
      req_base_ptr      <= r.bp;
      req_reg_ax        <= r.ax;
      req_reg_bx        <= r.bx;
      req_reg_cx        <= r.cx;
      req_reg_dx        <= r.dx;
      req_reg_si        <= r.si;
      req_reg_di        <= r.di;
      req_frame_size    <= r.frame_size;
      req_nesting_level <= r.nesting;
      req_push_value    <= r.push_value;
      req_valid         <= 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
      predicted = compute_stack_result(r);
      pending_results.push_back(predicted);
      chain_sp = predicted.sp;
      chain_bp = predicted.bp;
      kind_count[r.kind]++;
      if (r.kind == KIND_ENTER && int'(r.nesting) % NEST_WRAP >= 2) deep_enters++;
      if (r.kind <= KIND_LEAVE) ops_sent++;
   endtask

   // Continues the current frame from the predicted SP and BP; once in a
   // while a stray operation breaks the frame instead.
   task automatic chained_send(logic [KIND_W-1:0] kind);
      req_type r;
      r = random_request(kind, chain_sp, chain_bp);
      if ($urandom_range(0, 19) == 0) r = noise_request();
      send_item(r);
   endtask

   task automatic test_directed();
      req_type r;
      // Push word with SP wrapping below zero, then at the odd top offset.
      r = random_request(KIND_PUSH_WORD, 16'h0000, 16'h1234);
      r.push_value = 16'hFFFF;
      send_item(r);
      r = random_request(KIND_PUSH_WORD, 16'hFFFF, 16'hFFFF);
      r.push_value = 16'h0000;
      send_item(r);
      // Sign extension of the byte push, both signs.
      r = random_request(KIND_PUSH_BYTE, 16'h0200, 16'h0000);
      r.push_value = 16'hFF7F;
      send_item(r);
      r = random_request(KIND_PUSH_BYTE, 16'h0200, 16'h0000);
      r.push_value = 16'h0080;
      send_item(r);
      // Push all with ones everywhere across the zero boundary, then pop back.
      r = '{kind: KIND_PUSH_ALL, sp: 16'h0004, bp: 16'hFFFF, ax: 16'hFFFF, bx: 16'hFFFF,
            cx: 16'hFFFF, dx: 16'hFFFF, si: 16'hFFFF, di: 16'hFFFF, frame_size: 16'hFFFF,
            nesting: 8'hFF, push_value: 16'hFFFF};
      send_item(r);
      send_item(random_request(KIND_POP_ALL, chain_sp, 16'h0000));
      // Push all of zeros at an offset that wraps the word index.
      r = '{kind: KIND_PUSH_ALL, sp: 16'h0800, bp: 16'h0000, ax: 16'h0000, bx: 16'h0000,
            cx: 16'h0000, dx: 16'h0000, si: 16'h0000, di: 16'h0000, frame_size: 16'h0000,
            nesting: 8'h00, push_value: 16'h0000};
      send_item(r);
      send_item(random_request(KIND_POP_ALL, 16'hFFFA, 16'h0000));
      // Enter at nesting 0, 1, 2 and 31, and with nesting bytes that wrap.
      r = random_request(KIND_ENTER, 16'h0100, 16'h0200);
      r.nesting = 8'd0;
      r.frame_size = 16'h0000;
      send_item(r);
      r = random_request(KIND_ENTER, chain_sp, chain_bp);
      r.nesting = 8'd1;
      r.frame_size = 16'hFFFF;
      send_item(r);
      r = random_request(KIND_ENTER, chain_sp, chain_bp);
      r.nesting = 8'd2;
      r.frame_size = 16'h0010;
      send_item(r);
      r = random_request(KIND_ENTER, 16'h0040, 16'h0010);
      r.nesting = 8'd31;
      r.frame_size = 16'h0004;
      send_item(r);
      r = random_request(KIND_ENTER, chain_sp, chain_bp);
      r.nesting = 8'd32;
      send_item(r);
      r = random_request(KIND_ENTER, 16'h0301, chain_bp);
      r.nesting = 8'hFF;
      r.frame_size = 16'h8000;
      send_item(r);
      r = random_request(KIND_ENTER, chain_sp, chain_bp);
      r.nesting = 8'hE1;
      send_item(r);
      // Leave with BP at the top, at an odd offset, and closing a frame.
      send_item(random_request(KIND_LEAVE, 16'h1234, 16'hFFFE));
      send_item(random_request(KIND_LEAVE, 16'h1234, 16'h0003));
      r = random_request(KIND_ENTER, 16'h0500, 16'h0600);
      r.nesting = 8'd5;
      send_item(r);
      send_item(random_request(KIND_LEAVE, chain_sp, chain_bp));
      // The unused codes pass everything through.
      send_item(random_request(KIND_SPARE_6, 16'hABCD, 16'h0000));
      r = '{kind: KIND_SPARE_7, sp: 16'hFFFF, bp: 16'hFFFF, ax: 16'hFFFF, bx: 16'hFFFF,
            cx: 16'hFFFF, dx: 16'hFFFF, si: 16'hFFFF, di: 16'hFFFF, frame_size: 16'hFFFF,
            nesting: 8'hFF, push_value: 16'hFFFF};
      send_item(r);
      send_item(random_request(KIND_POP_ALL, 16'h0001, 16'h0000));
   endtask

   // The sink holds off for a long stretch while the source keeps offering,
   // so the engine fills its output register and stops taking requests.
   task automatic test_back_pressure();
      int i;
      hold_request = HOLD_CYCLES;
      burst_left   = PRESSURE_ITEMS;
      for (i = 0; i < PRESSURE_ITEMS; i++)
         send_item(random_request(KIND_W'($urandom_range(0, 5)), pick_stack_ptr(),
                                  pick_stack_ptr()));
   endtask

   // One procedure frame: arguments, push all, enter, locals, an optional
   // inner frame, leave and pop all, each step following the predicted
   // SP and BP.
   task automatic run_call_frame();
      int n_args;
      n_args   = $urandom_range(0, 3);
      chain_sp = pick_stack_ptr();
      chain_bp = pick_stack_ptr();
      repeat (n_args)
         chained_send($urandom_range(0, 1) ? KIND_PUSH_BYTE : KIND_PUSH_WORD);
      chained_send(KIND_PUSH_ALL);
      chained_send(KIND_ENTER);
      repeat ($urandom_range(0, 3))
         chained_send($urandom_range(0, 1) ? KIND_PUSH_BYTE : KIND_PUSH_WORD);
      if ($urandom_range(0, 3) == 0) begin
         chained_send(KIND_ENTER);
         chained_send(KIND_LEAVE);
      end
      chained_send(KIND_LEAVE);
      chained_send(KIND_POP_ALL);
   endtask

   task automatic test_random_frames();
      int start_ops;
      start_ops = ops_sent;
      while (ops_sent < start_ops + RANDOM_OPS) begin
         if ($urandom_range(0, 3) != 0) run_call_frame();
         else repeat ($urandom_range(1, 3)) send_item(noise_request());
      end
   endtask

   task automatic finish_run();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d transfers: push word %0d, push byte %0d, push all %0d, pop all %0d",
               responses_checked, kind_count[KIND_PUSH_WORD], kind_count[KIND_PUSH_BYTE],
               kind_count[KIND_PUSH_ALL], kind_count[KIND_POP_ALL]);
      $display("enter %0d (%0d nested two deep or more), leave %0d, unused codes %0d, %0d mismatches",
               kind_count[KIND_ENTER], deep_enters, kind_count[KIND_LEAVE],
               kind_count[KIND_SPARE_6] + kind_count[KIND_SPARE_7], mismatches);
      $display("Longest response hold-off: %0d cycles", longest_hold);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_back_pressure();
      test_random_frames();
      finish_run();
   end

   // --------------------------------------------------------- response side
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         longest_hold = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            pattern_mode = sink_mode_type'($urandom_range(0, 3));
            pattern_left = $urandom_range(10, 80);
         end
         pattern_left--;
         case (pattern_mode)
            SINK_STEADY: rsp_ready <= 1'b1;
            SINK_COIN:   rsp_ready <= ($urandom_range(0, 1) == 1);
            SINK_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
            default:     rsp_ready <= (pattern_left % 4 == 0);
         endcase
      end
   end

   task automatic check_field(string field, word_type want, word_type got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("response %0d: %s expected %h, got %h", responses_checked, field,
                     want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response transfer with nothing expected: SP %h BP %h",
                        rsp_new_stack_ptr, rsp_new_base_ptr);
         end else begin
            oldest_pending = pending_results.pop_front();
            check_field("SP", oldest_pending.sp, rsp_new_stack_ptr);
            check_field("BP", oldest_pending.bp, rsp_new_base_ptr);
            check_field("AX", oldest_pending.ax, rsp_out_ax);
            check_field("BX", oldest_pending.bx, rsp_out_bx);
            check_field("CX", oldest_pending.cx, rsp_out_cx);
            check_field("DX", oldest_pending.dx, rsp_out_dx);
            check_field("SI", oldest_pending.si, rsp_out_si);
            check_field("DI", oldest_pending.di, rsp_out_di);
         end
         responses_checked++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
                  pending_results.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

endmodule
